>>> rtl/core/ccr_pkg.sv
// ----------------------------------------------------------------------------
// ccr_pkg
// Shared types and constants for the chessboard corner reorder core.
// ----------------------------------------------------------------------------
package ccr_pkg;

  localparam int MAX_POINTS = 64;
  localparam int PT_AW      = $clog2(MAX_POINTS);
  localparam int COORD_BITS = 16;
  localparam int DIFF_BITS  = COORD_BITS + 1;
  localparam int CFG_BITS   = 6;
  localparam int CNT_BITS   = PT_AW + 1;

  localparam logic REG_BOARD_WIDTH  = 1'b0;
  localparam logic REG_BOARD_HEIGHT = 1'b1;

  localparam logic [CFG_BITS-1:0] BOARD_WIDTH_RST  = 6'd9;
  localparam logic [CFG_BITS-1:0] BOARD_HEIGHT_RST = 6'd6;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_REJECT,
    S_WRD,
    S_WDAT,
    S_WSLOPE,
    S_ROUT_RD,
    S_ROUT_DAT,
    S_RIN_RD,
    S_RIN_DAT,
    S_EMIT_RD,
    S_EMIT_PT,
    S_EMIT_OUT
  } state_e;

  typedef enum logic [2:0] {
    SL_IDLE,
    SL_MUL1,
    SL_MUL2,
    SL_MUL3,
    SL_CMP
  } slope_step_e;

  typedef struct packed {
    logic done;
    logic lt;
    logic gt;
  } slope_res_t;

endpackage

>>> rtl/core/ccr_ram.sv
// ----------------------------------------------------------------------------
// ccr_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module ccr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> rtl/core/ccr_slope.sv
// ----------------------------------------------------------------------------
// ccr_slope
// Multi-cycle slope comparator: one shared 17x17 multiplier, three products,
// then |dy1*dx2 - dy2*dx1| * 10 against |dx1*dx2|.
// ----------------------------------------------------------------------------
module ccr_slope (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  input  logic signed [ccr_pkg::DIFF_BITS-1:0] dx1_i,
  input  logic signed [ccr_pkg::DIFF_BITS-1:0] dy1_i,
  input  logic signed [ccr_pkg::DIFF_BITS-1:0] dx2_i,
  input  logic signed [ccr_pkg::DIFF_BITS-1:0] dy2_i,
  output ccr_pkg::slope_res_t                  res_o
);

  localparam int PW = 2 * ccr_pkg::DIFF_BITS;
  localparam int AW = PW + 1;
  localparam int CW = AW + 4;

  ccr_pkg::slope_step_e step_q, step_d;

  logic signed [ccr_pkg::DIFF_BITS-1:0] dx1_q, dy1_q, dx2_q, dy2_q;
  logic signed [ccr_pkg::DIFF_BITS-1:0] mul_a, mul_b;
  logic signed [PW-1:0] prod;
  logic signed [PW-1:0] m_q;
  logic signed [AW-1:0] a_q;
  logic [AW-1:0] num_abs;
  logic [PW-1:0] den_abs;
  logic [CW-1:0] num10, den_ext;
  logic v1, v2, lt_c, gt_c;
  logic done_q, lt_q, gt_q;

  always_comb begin
    case (step_q)
      ccr_pkg::SL_MUL1: begin mul_a = dy1_q; mul_b = dx2_q; end
      ccr_pkg::SL_MUL2: begin mul_a = dy2_q; mul_b = dx1_q; end
      default:          begin mul_a = dx1_q; mul_b = dx2_q; end
    endcase
  end

  assign prod = mul_a * mul_b;

  always_comb begin
    case (step_q)
      ccr_pkg::SL_IDLE: step_d = start_i ? ccr_pkg::SL_MUL1 : ccr_pkg::SL_IDLE;
      ccr_pkg::SL_MUL1: step_d = ccr_pkg::SL_MUL2;
      ccr_pkg::SL_MUL2: step_d = ccr_pkg::SL_MUL3;
      ccr_pkg::SL_MUL3: step_d = ccr_pkg::SL_CMP;
      default:          step_d = ccr_pkg::SL_IDLE;
    endcase
  end

  // final compare on registered numerator and denominator
  assign num_abs = a_q[AW-1] ? AW'(-a_q) : AW'(a_q);
  assign den_abs = m_q[PW-1] ? PW'(-m_q) : PW'(m_q);
  assign num10   = {1'b0, num_abs, 3'b000} + {3'b000, num_abs, 1'b0};
  assign den_ext = CW'(den_abs);
  assign v1      = (dx1_q == '0);
  assign v2      = (dx2_q == '0);
  assign lt_c    = (v1 & v2) | (~v1 & ~v2 & (num10 < den_ext));
  assign gt_c    = (v1 ^ v2) | (~v1 & ~v2 & (num10 > den_ext));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= ccr_pkg::SL_IDLE;
      done_q <= 1'b0;
      lt_q   <= 1'b0;
      gt_q   <= 1'b0;
    end else begin
      step_q <= step_d;
      done_q <= (step_q == ccr_pkg::SL_CMP);
      if (step_q == ccr_pkg::SL_CMP) begin
        lt_q <= lt_c;
        gt_q <= gt_c;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && step_q == ccr_pkg::SL_IDLE) begin
      dx1_q <= dx1_i;
      dy1_q <= dy1_i;
      dx2_q <= dx2_i;
      dy2_q <= dy2_i;
    end
    case (step_q)
      ccr_pkg::SL_MUL1: m_q <= prod;
      ccr_pkg::SL_MUL2: begin
        a_q <= AW'(m_q);
        m_q <= prod;
      end
      ccr_pkg::SL_MUL3: begin
        a_q <= a_q - AW'(m_q);
        m_q <= prod;
      end
      default: ;
    endcase
  end

  assign res_o.done = done_q;
  assign res_o.lt   = lt_q;
  assign res_o.gt   = gt_q;

endmodule

>>> rtl/core/chessboard_corner_reorder_core.sv
// ----------------------------------------------------------------------------
// chessboard_corner_reorder_core
// Collects chessboard corners, checks layout and collinearity, sorts groups
// and points, and emits the corners in row-major order or a rejection.
// ----------------------------------------------------------------------------
// Loading: one corner per cycle while busy is low; no result for a non-last item.
// After the last corner: a slope test per point walked past the first two of a group,
// then rank compares with an extra step per ranked element
// (groups^2 + n*len compares), then the results; a rejection follows the check
// after the last corner or comes right after the failing slope test. One set at a time.
// Reset: count, overflow flag, 9 x 6 registers, idle sequencer; receiver cannot stall.
module chessboard_corner_reorder_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic [ccr_pkg::COORD_BITS-1:0]      x_i,
  input  logic [ccr_pkg::COORD_BITS-1:0]      y_i,
  input  logic                                last_i,
  input  logic                                cfg_we_i,
  input  logic                                cfg_idx_i,
  input  logic [ccr_pkg::CFG_BITS-1:0]        cfg_wdata_i,
  output logic                                out_valid_o,
  output logic [ccr_pkg::COORD_BITS-1:0]      out_x_o,
  output logic [ccr_pkg::COORD_BITS-1:0]      out_y_o,
  output logic                                status_o,
  output logic                                end_of_set_o
);

  localparam int CB = ccr_pkg::COORD_BITS;
  localparam int AW = ccr_pkg::PT_AW;
  localparam int DB = ccr_pkg::DIFF_BITS;
  localparam int GB = AW - 1;              // group / rank index bits
  localparam int MB = GB + ccr_pkg::CFG_BITS;

  ccr_pkg::state_e state_q, state_d;

  logic [ccr_pkg::CFG_BITS-1:0] bw_q, bh_q;
  logic [ccr_pkg::CNT_BITS-1:0] cnt_q;
  logic                         ovf_q;
  logic                         layout_q, cols_q, pm_q;
  logic [ccr_pkg::CFG_BITS-1:0] groups_q, len_q;
  logic [AW-1:0]                base_q, idx_q, pos_q;
  logic [GB-1:0]                g_q, o_q, j_q, rcnt_q;
  logic [GB-1:0]                grank_q [2**GB];
  logic [CB-1:0]                prev_x_q, prev_y_q, okey_q;
  logic signed [DB-1:0]         dx1_q, dy1_q;

  // memories
  logic                pt_we;
  logic [AW-1:0]       pt_raddr;
  logic [2*CB-1:0]     pt_rdata;
  logic                oi_we;
  logic [AW-1:0]       oi_waddr;
  logic [AW-1:0]       oi_wdata;
  logic [AW-1:0]       oi_rdata;

  logic [CB-1:0] rd_x, rd_y;
  assign rd_x = pt_rdata[2*CB-1:CB];
  assign rd_y = pt_rdata[CB-1:0];

  ccr_ram #(.WIDTH(2 * CB), .DEPTH(ccr_pkg::MAX_POINTS)) u_point_ram (
    .clk_i   (clk_i),
    .we_i    (pt_we),
    .waddr_i (cnt_q[AW-1:0]),
    .wdata_i ({x_i, y_i}),
    .raddr_i (pt_raddr),
    .rdata_o (pt_rdata)
  );

  ccr_ram #(.WIDTH(AW), .DEPTH(ccr_pkg::MAX_POINTS)) u_order_ram (
    .clk_i   (clk_i),
    .we_i    (oi_we),
    .waddr_i (oi_waddr),
    .wdata_i (oi_wdata),
    .raddr_i (pos_q),
    .rdata_o (oi_rdata)
  );

  // slope unit
  logic                slope_start;
  logic signed [DB-1:0] seg_dx, seg_dy;
  ccr_pkg::slope_res_t slope_res;

  assign seg_dx = DB'(signed'({1'b0, rd_x})) - DB'(signed'({1'b0, prev_x_q}));
  assign seg_dy = DB'(signed'({1'b0, rd_y})) - DB'(signed'({1'b0, prev_y_q}));

  ccr_slope u_slope (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (slope_start),
    .dx1_i   (dx1_q),
    .dy1_i   (dy1_q),
    .dx2_i   (seg_dx),
    .dy2_i   (seg_dy),
    .res_o   (slope_res)
  );

  // shared control terms
  logic                          accept;
  logic [2*ccr_pkg::CFG_BITS-1:0] area;
  logic                          reject_c;
  logic [ccr_pkg::CFG_BITS-1:0]  walk_m, rank_n;
  logic                          walk_last, g_last, j_last, o_last, emit_last;
  logic [MB-1:0]                 prod_o, prod_j, prod_pos;
  logic [AW-1:0]                 addr_o, addr_j;
  logic                          key_y, ahead;
  logic [CB-1:0]                 rkey;
  logic [GB-1:0]                 rank_now, grk;

  assign busy   = (state_q != ccr_pkg::S_IDLE);
  assign accept = start & ~busy;
  assign area   = bw_q * bh_q;
  assign reject_c = ovf_q | (bw_q < 6'd2) | (bh_q < 6'd2) | (bw_q == bh_q) |
                    ((2*ccr_pkg::CFG_BITS)'(cnt_q) != area);

  assign walk_m    = layout_q ? 6'd3 : len_q;
  assign walk_last = ({1'b0, idx_q[AW-2:0]} == walk_m - 6'd1) && !idx_q[AW-1];
  assign g_last    = ({1'b0, g_q} == groups_q - 6'd1);
  assign rank_n    = pm_q ? len_q : groups_q;
  assign j_last    = ({1'b0, j_q} == rank_n - 6'd1);
  assign o_last    = ({1'b0, o_q} == rank_n - 6'd1);
  assign emit_last = ({1'b0, pos_q} == cnt_q - 7'd1);

  // group g's base is g*len; point e of group g sits at g*len + e
  assign prod_o = MB'(pm_q ? g_q : o_q) * MB'(len_q);
  assign prod_j = MB'(pm_q ? g_q : j_q) * MB'(len_q);
  assign addr_o = prod_o[AW-1:0] + (pm_q ? {1'b0, o_q} : '0);
  assign addr_j = prod_j[AW-1:0] + (pm_q ? {1'b0, j_q} : '0);

  // y keys sort descending, x keys ascending
  assign key_y    = ~(cols_q ^ pm_q);
  assign rkey     = key_y ? rd_y : rd_x;
  assign ahead    = (key_y ? (rkey > okey_q) : (rkey < okey_q)) |
                    ((rkey == okey_q) & (j_q < o_q));
  assign rank_now = rcnt_q + GB'(ahead);
  assign grk      = grank_q[g_q];

  // columns: row r, column grk; rows: row grk, column r; row length is width
  assign prod_pos = MB'(cols_q ? rank_now : grk) * MB'(bw_q);
  assign oi_waddr = prod_pos[AW-1:0] + {1'b0, (cols_q ? grk : rank_now)};
  assign oi_wdata = addr_o;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ccr_pkg::S_IDLE:     if (accept && last_i) state_d = ccr_pkg::S_CHECK;
      ccr_pkg::S_CHECK:    state_d = reject_c ? ccr_pkg::S_REJECT : ccr_pkg::S_WRD;
      ccr_pkg::S_REJECT:   state_d = ccr_pkg::S_IDLE;
      ccr_pkg::S_WRD:      state_d = ccr_pkg::S_WDAT;
      ccr_pkg::S_WDAT: begin
        if (idx_q >= 6'd2) state_d = ccr_pkg::S_WSLOPE;
        else if (walk_last) state_d = g_last ? ccr_pkg::S_ROUT_RD : ccr_pkg::S_WRD;
        else state_d = ccr_pkg::S_WRD;
      end
      ccr_pkg::S_WSLOPE: begin
        if (slope_res.done) begin
          if (layout_q) state_d = ccr_pkg::S_WRD;
          else if (slope_res.gt) state_d = ccr_pkg::S_REJECT;
          else if (walk_last) state_d = g_last ? ccr_pkg::S_ROUT_RD : ccr_pkg::S_WRD;
          else state_d = ccr_pkg::S_WRD;
        end
      end
      ccr_pkg::S_ROUT_RD:  state_d = ccr_pkg::S_ROUT_DAT;
      ccr_pkg::S_ROUT_DAT: state_d = ccr_pkg::S_RIN_RD;
      ccr_pkg::S_RIN_RD:   state_d = ccr_pkg::S_RIN_DAT;
      ccr_pkg::S_RIN_DAT: begin
        if (!j_last) state_d = ccr_pkg::S_RIN_RD;
        else if (o_last && pm_q && g_last) state_d = ccr_pkg::S_EMIT_RD;
        else state_d = ccr_pkg::S_ROUT_RD;
      end
      ccr_pkg::S_EMIT_RD:  state_d = ccr_pkg::S_EMIT_PT;
      ccr_pkg::S_EMIT_PT:  state_d = ccr_pkg::S_EMIT_OUT;
      ccr_pkg::S_EMIT_OUT: state_d = emit_last ? ccr_pkg::S_IDLE : ccr_pkg::S_EMIT_RD;
      default:             state_d = ccr_pkg::S_IDLE;
    endcase
  end

  // outputs and memory controls
  always_comb begin
    pt_we        = accept & ~cnt_q[AW];
    pt_raddr     = base_q + idx_q;
    oi_we        = 1'b0;
    slope_start  = 1'b0;
    out_valid_o  = 1'b0;
    out_x_o      = '0;
    out_y_o      = '0;
    status_o     = 1'b0;
    end_of_set_o = 1'b0;
    case (state_q)
      ccr_pkg::S_WDAT:    slope_start = (idx_q >= 6'd2);
      ccr_pkg::S_ROUT_RD: pt_raddr = addr_o;
      ccr_pkg::S_RIN_RD:  pt_raddr = addr_j;
      ccr_pkg::S_RIN_DAT: oi_we = j_last & pm_q;
      ccr_pkg::S_EMIT_PT: pt_raddr = oi_rdata;
      ccr_pkg::S_REJECT: begin
        out_valid_o  = 1'b1;
        status_o     = 1'b1;
        end_of_set_o = 1'b1;
      end
      ccr_pkg::S_EMIT_OUT: begin
        out_valid_o  = 1'b1;
        out_x_o      = rd_x;
        out_y_o      = rd_y;
        end_of_set_o = emit_last;
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ccr_pkg::S_IDLE;
      bw_q     <= ccr_pkg::BOARD_WIDTH_RST;
      bh_q     <= ccr_pkg::BOARD_HEIGHT_RST;
      cnt_q    <= '0;
      ovf_q    <= 1'b0;
      layout_q <= 1'b0;
      cols_q   <= 1'b0;
      pm_q     <= 1'b0;
      groups_q <= '0;
      len_q    <= '0;
      base_q   <= '0;
      idx_q    <= '0;
      pos_q    <= '0;
      g_q      <= '0;
      o_q      <= '0;
      j_q      <= '0;
      rcnt_q   <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        if (cfg_idx_i == ccr_pkg::REG_BOARD_WIDTH) bw_q <= cfg_wdata_i;
        else bh_q <= cfg_wdata_i;
      end
      case (state_q)
        ccr_pkg::S_IDLE: begin
          if (accept) begin
            if (!cnt_q[AW]) cnt_q <= cnt_q + 7'd1;
            else ovf_q <= 1'b1;
          end
        end
        ccr_pkg::S_CHECK: begin
          base_q   <= bw_q - 6'd2;
          idx_q    <= '0;
          layout_q <= 1'b1;
        end
        ccr_pkg::S_REJECT: begin
          cnt_q <= '0;
          ovf_q <= 1'b0;
        end
        ccr_pkg::S_WDAT: begin
          if (idx_q < 6'd2) begin
            if (walk_last) begin
              idx_q  <= '0;
              base_q <= base_q + len_q;
              g_q    <= g_q + 5'd1;
              pm_q   <= 1'b0;
              o_q    <= '0;
            end else begin
              idx_q <= idx_q + 6'd1;
            end
          end
        end
        ccr_pkg::S_WSLOPE: begin
          if (slope_res.done) begin
            if (layout_q) begin
              layout_q <= 1'b0;
              cols_q   <= slope_res.lt;
              groups_q <= slope_res.lt ? bw_q : bh_q;
              len_q    <= slope_res.lt ? bh_q : bw_q;
              g_q      <= '0;
              base_q   <= '0;
              idx_q    <= '0;
            end else if (walk_last) begin
              idx_q  <= '0;
              base_q <= base_q + len_q;
              g_q    <= g_q + 5'd1;
              pm_q   <= 1'b0;
              o_q    <= '0;
            end else begin
              idx_q <= idx_q + 6'd1;
            end
          end
        end
        ccr_pkg::S_ROUT_DAT: begin
          j_q    <= '0;
          rcnt_q <= '0;
        end
        ccr_pkg::S_RIN_DAT: begin
          rcnt_q <= rank_now;
          j_q    <= j_q + 5'd1;
          if (j_last) begin
            o_q <= o_q + 5'd1;
            if (o_last) begin
              o_q   <= '0;
              pos_q <= '0;
              if (!pm_q) begin
                pm_q <= 1'b1;
                g_q  <= '0;
              end else begin
                g_q <= g_q + 5'd1;
              end
            end
          end
        end
        ccr_pkg::S_EMIT_OUT: begin
          pos_q <= pos_q + 6'd1;
          if (emit_last) begin
            cnt_q <= '0;
            ovf_q <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (state_q == ccr_pkg::S_WDAT) begin
      prev_x_q <= rd_x;
      prev_y_q <= rd_y;
      if (idx_q == 6'd1) begin
        dx1_q <= seg_dx;
        dy1_q <= seg_dy;
      end
    end
    if (state_q == ccr_pkg::S_ROUT_DAT) okey_q <= rkey;
    if (state_q == ccr_pkg::S_RIN_DAT && j_last && !pm_q) grank_q[o_q] <= rank_now;
  end

  // checks
  a_reject_ends_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o |-> end_of_set_o)
    else $error("rejection not marked end of set");

  a_reject_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o |-> (out_x_o == '0) && (out_y_o == '0))
    else $error("rejection carries coordinates");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 7'(ccr_pkg::MAX_POINTS))
    else $error("point count beyond store");

  a_last_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && last_i |=> busy && (state_q == ccr_pkg::S_CHECK))
    else $error("last item did not start processing");

  a_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && end_of_set_o |=> (cnt_q == '0) && !ovf_q && !busy)
    else $error("set end did not clear count");

endmodule
